[hdl/lwer_pkg.sv]
// shared types and constants for the low-water event ring
`timescale 1ns / 1ps
`default_nettype none

package lwer_pkg;

  // ring geometry
  localparam int EVENT_DEPTH = 16;
  localparam int SLOT_W      = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
  localparam int COUNT_W     = $clog2(EVENT_DEPTH + 1);
  localparam int SUM_W       = COUNT_W + 1;
  localparam int LIMIT_W     = 7;

  // field widths
  localparam int WORD_W = 32;
  localparam int MODE_W = 8;
  localparam int TIME_W = 64;

  // opcodes
  localparam logic OP_NOTE = 1'b0;
  localparam logic OP_DUMP = 1'b1;

  // reset values
  localparam logic [WORD_W-1:0] STEP_RESET   = 32'd1024;
  localparam logic [WORD_W-1:0] LOWEST_RESET = '1;

  // controller states
  typedef enum logic [0:0] {
    ST_IDLE,
    ST_DUMP
  } state_t;

  // one logged event
  typedef struct packed {
    logic [WORD_W-1:0] heap_min;
    logic [WORD_W-1:0] largest;
    logic [WORD_W-1:0] queued;
    logic [MODE_W-1:0] mode;
    logic [TIME_W-1:0] time_us;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic note_load;   // take a note item, log it if low enough, emit its result
    logic empty_load;  // emit the result of an empty dump
    logic dump_start;  // latch dump window and read its first entry
    logic dump_step;   // emit the fetched entry and read the next one
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;    // output register can take a result this cycle
    logic op_dump;     // pending input item is a dump
    logic dump_empty;  // pending dump returns nothing
    logic dump_last;   // fetched entry is the final one of the dump
  } status_t;

endpackage

`default_nettype wire

[hdl/lwer_ctrl.sv]
// controller state machine for the low-water event ring
`timescale 1ns / 1ps
`default_nettype none

module lwer_ctrl
  import lwer_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state;
  state_t state_next;
  logic   accept;

  // input is taken only when idle and the output register frees up
  assign in_stall = !((state == ST_IDLE) && status.out_free);
  assign accept   = in_valid && !in_stall;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && status.op_dump && !status.dump_empty) begin
          state_next = ST_DUMP;
        end
      end
      ST_DUMP: begin
        if (status.out_free && status.dump_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (!status.op_dump) begin
            cmd.note_load = 1'b1;
          end else if (status.dump_empty) begin
            cmd.empty_load = 1'b1;
          end else begin
            cmd.dump_start = 1'b1;
          end
        end
      end
      ST_DUMP: begin
        cmd.dump_step = status.out_free;
      end
      default: cmd = '0;
    endcase
  end

  // checks
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.note_load, cmd.empty_load, cmd.dump_start, cmd.dump_step}))
    else $error("more than one datapath command");

  a_start_enters_dump: assert property (@(posedge clk) disable iff (rst)
    cmd.dump_start |=> state == ST_DUMP)
    else $error("dump start did not enter dump state");

  a_no_take_in_dump: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DUMP) |-> in_stall)
    else $error("input item taken during a dump");

endmodule

`default_nettype wire

[hdl/lwer_dp.sv]
// datapath: tracker, event ring memory and output register
`timescale 1ns / 1ps
`default_nettype none

module lwer_dp
  import lwer_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_write,
  input  wire logic        [WORD_W-1:0] cfg_data,
  input  wire logic                     opcode,
  input  wire logic        [WORD_W-1:0] heap_min,
  input  wire logic        [WORD_W-1:0] largest_block,
  input  wire logic        [WORD_W-1:0] queued_items,
  input  wire logic        [MODE_W-1:0] mode_code,
  input  wire logic signed [TIME_W-1:0] time_us,
  input  wire logic       [LIMIT_W-1:0] read_limit,
  input  wire logic                     out_stall,
  input  wire cmd_t                     cmd,
  output status_t                       status,
  output logic                          out_valid,
  output logic                          recorded,
  output logic                          entry_valid,
  output logic             [WORD_W-1:0] out_free_min,
  output logic             [WORD_W-1:0] out_largest_block,
  output logic             [WORD_W-1:0] out_queued_items,
  output logic             [MODE_W-1:0] out_mode_code,
  output logic signed      [TIME_W-1:0] out_time_us,
  output logic                          last
);

  // event ring
  entry_t ring [EVENT_DEPTH];
  entry_t rd_data;

  logic [WORD_W-1:0]  low_water_step;
  logic [WORD_W-1:0]  lowest_logged;
  logic [SLOT_W-1:0]  write_slot;
  logic [COUNT_W-1:0] held_count;
  logic [SLOT_W-1:0]  rd_slot;
  logic [COUNT_W-1:0] remain;

  logic               log_hit;
  logic [COUNT_W-1:0] dump_n;
  logic [SUM_W-1:0]   base_sum;
  logic [SLOT_W-1:0]  dump_base;
  logic [SLOT_W-1:0]  rd_addr;
  logic               rd_en;
  logic               out_load;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    if (s == SLOT_W'(EVENT_DEPTH - 1)) begin
      return '0;
    end
    return s + SLOT_W'(1);
  endfunction

  // low-water compare on a 33-bit sum
  assign log_hit = ({1'b0, heap_min} + {1'b0, low_water_step}) < {1'b0, lowest_logged};

  // dump window: newest min(held, limit) entries
  always_comb begin
    if (read_limit < LIMIT_W'(held_count)) begin
      dump_n = read_limit[COUNT_W-1:0];
    end else begin
      dump_n = held_count;
    end
    if (SUM_W'(write_slot) >= SUM_W'(dump_n)) begin
      base_sum = SUM_W'(write_slot) - SUM_W'(dump_n);
    end else begin
      base_sum = SUM_W'(write_slot) + SUM_W'(EVENT_DEPTH) - SUM_W'(dump_n);
    end
    dump_base = base_sum[SLOT_W-1:0];
  end

  assign rd_en   = cmd.dump_start || cmd.dump_step;
  assign rd_addr = cmd.dump_start ? dump_base : rd_slot;

  // status to controller
  assign status.out_free   = !out_valid || !out_stall;
  assign status.op_dump    = (opcode == OP_DUMP);
  assign status.dump_empty = (dump_n == '0);
  assign status.dump_last  = (remain == COUNT_W'(1));

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      low_water_step <= STEP_RESET;
    end else if (cfg_write) begin
      low_water_step <= cfg_data;
    end
  end

  // tracker and ring pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      lowest_logged <= LOWEST_RESET;
      write_slot    <= '0;
      held_count    <= '0;
    end else if (cmd.note_load && log_hit) begin
      lowest_logged <= heap_min;
      write_slot    <= slot_inc(write_slot);
      if (held_count < COUNT_W'(EVENT_DEPTH)) begin
        held_count <= held_count + COUNT_W'(1);
      end
    end
  end

  // ring write port
  always_ff @(posedge clk) begin
    if (cmd.note_load && log_hit) begin
      ring[write_slot] <= '{heap_min: heap_min, largest: largest_block,
                            queued: queued_items, mode: mode_code,
                            time_us: time_us};
    end
  end

  // ring read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= ring[rd_addr];
    end
  end

  // dump walk
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_slot <= '0;
      remain  <= '0;
    end else if (cmd.dump_start) begin
      rd_slot <= slot_inc(dump_base);
      remain  <= dump_n;
    end else if (cmd.dump_step) begin
      rd_slot <= slot_inc(rd_slot);
      remain  <= remain - COUNT_W'(1);
    end
  end

  assign out_load = cmd.note_load || cmd.empty_load || cmd.dump_step;

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      recorded          <= cmd.note_load && log_hit;
      entry_valid       <= cmd.dump_step;
      last              <= !cmd.dump_step || status.dump_last;
      out_free_min      <= cmd.dump_step ? rd_data.heap_min : '0;
      out_largest_block <= cmd.dump_step ? rd_data.largest : '0;
      out_queued_items  <= cmd.dump_step ? rd_data.queued : '0;
      out_mode_code     <= cmd.dump_step ? rd_data.mode : '0;
      out_time_us       <= cmd.dump_step ? signed'(rd_data.time_us) : '0;
    end
  end

  // checks
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= COUNT_W'(EVENT_DEPTH))
    else $error("held count beyond ring depth");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> status.out_free)
    else $error("result loaded over a stalled item");

  a_low_water_falls: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> lowest_logged <= $past(lowest_logged))
    else $error("low-water mark went up");

  a_rec_xor_entry: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(recorded && entry_valid))
    else $error("result marked both recorded and entry");

endmodule

`default_nettype wire

[hdl/low_water_event_ring_core.sv]
// top level of the low-water event ring
//
//   channel | signals                        | direction | accepted when
//   --------+--------------------------------+-----------+----------------------
//   input   | in_valid, in_stall, fields     | in        | in_valid && !in_stall
//   output  | out_valid, out_stall, fields   | out       | out_valid && !out_stall
//   config  | cfg_write, cfg_data            | in        | cfg_write
//
// a note item gives one result; notes stream every cycle unless the output stalls
// a dump of n events fetches its first entry from the ring read port, then streams
//   one result per cycle unless the output stalls; input is held off until it ends
// an empty dump gives a single result
// a stalled output holds its item and holds off the next input item
// synchronous reset clears pointers and held count, sets low-water mark to all ones, step to 1024
`timescale 1ns / 1ps
`default_nettype none

module low_water_event_ring_core
  import lwer_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_write,
  input  wire logic        [WORD_W-1:0] cfg_data,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic                     opcode,
  input  wire logic        [WORD_W-1:0] heap_min,
  input  wire logic        [WORD_W-1:0] largest_block,
  input  wire logic        [WORD_W-1:0] queued_items,
  input  wire logic        [MODE_W-1:0] mode_code,
  input  wire logic signed [TIME_W-1:0] time_us,
  input  wire logic       [LIMIT_W-1:0] read_limit,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic                          recorded,
  output logic                          entry_valid,
  output logic             [WORD_W-1:0] out_free_min,
  output logic             [WORD_W-1:0] out_largest_block,
  output logic             [WORD_W-1:0] out_queued_items,
  output logic             [MODE_W-1:0] out_mode_code,
  output logic signed      [TIME_W-1:0] out_time_us,
  output logic                          last
);

  cmd_t    cmd;
  status_t status;

  // sequencing
  lwer_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // tracker, ring and output register
  lwer_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_data          (cfg_data),
    .opcode            (opcode),
    .heap_min          (heap_min),
    .largest_block     (largest_block),
    .queued_items      (queued_items),
    .mode_code         (mode_code),
    .time_us           (time_us),
    .read_limit        (read_limit),
    .out_stall         (out_stall),
    .cmd               (cmd),
    .status            (status),
    .out_valid         (out_valid),
    .recorded          (recorded),
    .entry_valid       (entry_valid),
    .out_free_min      (out_free_min),
    .out_largest_block (out_largest_block),
    .out_queued_items  (out_queued_items),
    .out_mode_code     (out_mode_code),
    .out_time_us       (out_time_us),
    .last              (last)
  );

endmodule

`default_nettype wire

[tb/tb_top.sv]
// self-checking testbench for the low-water event ring core
`timescale 1ns / 1ps

module tb_top
  import lwer_pkg::*;
();

  localparam int IDLE_PCT = 19;
  localparam int HOLD_CYCLES = 240;

  // one heap note or dump request as offered on the input channel
  typedef struct {
    logic               op;
    logic [WORD_W-1:0]  heap_min;
    logic [WORD_W-1:0]  largest;
    logic [WORD_W-1:0]  queued;
    logic [MODE_W-1:0]  mode;
    logic [TIME_W-1:0]  time_us;
    logic [LIMIT_W-1:0] limit;
  } heap_sample_t;

  // one item seen on the output channel
  typedef struct {
    logic              recorded;
    logic              entry_valid;
    logic [WORD_W-1:0] heap_min;
    logic [WORD_W-1:0] largest;
    logic [WORD_W-1:0] queued;
    logic [MODE_W-1:0] mode;
    logic [TIME_W-1:0] time_us;
    logic              last;
  } event_result_t;

  // low-water tracker and event ring mirror, plus the queue of awaited results
  class ring_scoreboard;
    entry_t            ring [EVENT_DEPTH];
    int                next_slot;
    int                held;
    logic [WORD_W-1:0] lowest;
    logic [WORD_W-1:0] step;
    event_result_t     awaited_q [$];
    int                errors;
    int                notes_seen;
    int                logged_seen;
    int                dumps_seen;
    int                results_seen;

    function new();
      next_slot    = 0;
      held         = 0;
      lowest       = LOWEST_RESET;
      step         = STEP_RESET;
      errors       = 0;
      notes_seen   = 0;
      logged_seen  = 0;
      dumps_seen   = 0;
      results_seen = 0;
    endfunction

    function void set_step(logic [WORD_W-1:0] value);
      step = value;
    endfunction

    // work out the results an accepted item causes and queue them
    function void take_item(heap_sample_t it);
      event_result_t r;
      entry_t        e;
      logic [WORD_W:0] sum;
      int            n;
      r = '{default: '0};
      if (it.op == OP_NOTE) begin
        notes_seen++;
        // 33-bit sum, no wrap
        sum = {1'b0, it.heap_min} + {1'b0, step};
        if (sum < {1'b0, lowest}) begin
          lowest = it.heap_min;
          ring[next_slot] = '{it.heap_min, it.largest, it.queued, it.mode, it.time_us};
          next_slot = (next_slot + 1) % EVENT_DEPTH;
          if (held < EVENT_DEPTH) held++;
          r.recorded = 1'b1;
          logged_seen++;
        end
        r.last = 1'b1;
        awaited_q.push_back(r);
      end else begin
        dumps_seen++;
        n = (held < int'(it.limit)) ? held : int'(it.limit);
        // nothing held or zero limit gives one empty result
        if (n == 0) begin
          r.last = 1'b1;
          awaited_q.push_back(r);
        end
        // newest n events, oldest first
        for (int i = 0; i < n; i++) begin
          e = ring[(next_slot + EVENT_DEPTH - n + i) % EVENT_DEPTH];
          r.entry_valid = 1'b1;
          r.heap_min    = e.heap_min;
          r.largest     = e.largest;
          r.queued      = e.queued;
          r.mode        = e.mode;
          r.time_us     = e.time_us;
          r.last        = (i == n - 1);
          awaited_q.push_back(r);
        end
      end
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    // compare an accepted result with the oldest awaited one
    function void check_result(event_result_t got);
      event_result_t want;
      results_seen++;
      if (awaited_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual out_free_min %h last %b",
                 $time, got.heap_min, got.last);
        return;
      end
      want = awaited_q.pop_front();
      compare_field("recorded", want.recorded, got.recorded);
      compare_field("entry_valid", want.entry_valid, got.entry_valid);
      compare_field("out_free_min", want.heap_min, got.heap_min);
      compare_field("out_largest_block", want.largest, got.largest);
      compare_field("out_queued_items", want.queued, got.queued);
      compare_field("out_mode_code", want.mode, got.mode);
      compare_field("out_time_us", want.time_us, got.time_us);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic                      cfg_write;
  logic         [WORD_W-1:0] cfg_data;
  logic                      in_valid;
  logic                      in_stall;
  logic                      opcode;
  logic         [WORD_W-1:0] heap_min;
  logic         [WORD_W-1:0] largest_block;
  logic         [WORD_W-1:0] queued_items;
  logic         [MODE_W-1:0] mode_code;
  logic signed  [TIME_W-1:0] time_us;
  logic        [LIMIT_W-1:0] read_limit;
  logic                      out_valid;
  logic                      out_stall;
  logic                      recorded;
  logic                      entry_valid;
  logic         [WORD_W-1:0] out_free_min;
  logic         [WORD_W-1:0] out_largest_block;
  logic         [WORD_W-1:0] out_queued_items;
  logic         [MODE_W-1:0] out_mode_code;
  logic signed  [TIME_W-1:0] out_time_us;
  logic                      last;

  ring_scoreboard sb = new();
  bit quiet    = 1'b0;
  bit hold_req = 1'b0;
  int steps_used = 1;

  low_water_event_ring_core dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .opcode            (opcode),
    .heap_min          (heap_min),
    .largest_block     (largest_block),
    .queued_items      (queued_items),
    .mode_code         (mode_code),
    .time_us           (time_us),
    .read_limit        (read_limit),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .recorded          (recorded),
    .entry_valid       (entry_valid),
    .out_free_min      (out_free_min),
    .out_largest_block (out_largest_block),
    .out_queued_items  (out_queued_items),
    .out_mode_code     (out_mode_code),
    .out_time_us       (out_time_us),
    .last              (last)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // output stall: random, quiet, or a long counted hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    event_result_t got;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      got.recorded    = recorded;
      got.entry_valid = entry_valid;
      got.heap_min    = out_free_min;
      got.largest     = out_largest_block;
      got.queued      = out_queued_items;
      got.mode        = out_mode_code;
      got.time_us     = out_time_us;
      got.last        = last;
      sb.check_result(got);
    end
  end

  // heap minimum that logs, or one at or above the logging threshold
  function automatic logic [WORD_W-1:0] pick_free(bit want_log);
    longint unsigned top;
    longint unsigned lo;
    longint unsigned span;
    if (want_log && sb.lowest > sb.step) begin
      top = longint'(sb.lowest) - sb.step - 1;
      return WORD_W'(top - ((top > 4096) ? $urandom_range(0, 4096) : $urandom_range(0, top)));
    end
    lo   = (sb.lowest > sb.step) ? longint'(sb.lowest) - sb.step : 0;
    span = 64'h1_0000_0000 - lo;
    return WORD_W'(lo + ($urandom % span));
  endfunction

  function automatic heap_sample_t note_item(logic [WORD_W-1:0] fm);
    heap_sample_t it;
    it.op       = OP_NOTE;
    it.heap_min = fm;
    it.largest  = $urandom;
    it.queued   = $urandom;
    it.mode     = MODE_W'($urandom_range(0, 255));
    it.time_us  = {$urandom, $urandom};
    it.limit    = LIMIT_W'($urandom_range(0, 64));
    return it;
  endfunction

  function automatic heap_sample_t dump_item(int limit);
    heap_sample_t it;
    it       = note_item($urandom);
    it.op    = OP_DUMP;
    it.limit = LIMIT_W'(limit);
    return it;
  endfunction

  function automatic int pick_limit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 30) return 64;
    if (r < 50) return 1;
    if (r < 75) return $urandom_range(2, 63);
    return $urandom_range(2, 20);
  endfunction

  // offer one item, with random idle cycles ahead of it, until accepted
  task automatic send_item(heap_sample_t it);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    opcode        <= it.op;
    heap_min      <= it.heap_min;
    largest_block <= it.largest;
    queued_items  <= it.queued;
    mode_code     <= it.mode;
    time_us       <= it.time_us;
    read_limit    <= it.limit;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.take_item(it);
  endtask

  // mostly well-formed logging notes, some notes at or above the logging threshold, dumps
  task automatic run_random(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 25) send_item(dump_item(pick_limit()));
      else if (r < 85) send_item(note_item(pick_free(1'b1)));
      else send_item(note_item(pick_free(1'b0)));
    end
  endtask

  // drain everything awaited, then let the pipeline settle
  task automatic end_phase();
    in_valid <= 1'b0;
    while (sb.awaited_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_step(logic [WORD_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_step(value);
    steps_used++;
  endtask

  // stimulus
  initial begin
    heap_sample_t it;
    rst           <= 1'b1;
    cfg_write     <= 1'b0;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    opcode        <= OP_NOTE;
    heap_min      <= '0;
    largest_block <= '0;
    queued_items  <= '0;
    mode_code     <= '0;
    time_us       <= '0;
    read_limit    <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty ring dumps
    send_item(dump_item(5));
    send_item(dump_item(0));
    // at the mark, then exactly at the threshold, then just under it
    it = note_item(32'hFFFF_FFFF);
    it.largest = '0;
    it.queued  = '1;
    it.mode    = '0;
    it.time_us = 64'h8000_0000_0000_0000;
    send_item(it);
    send_item(note_item(32'hFFFF_FFFF - 1024));
    it = note_item(32'hFFFF_FFFF - 1025);
    it.largest = '1;
    it.queued  = '0;
    it.mode    = '1;
    it.time_us = 64'h7FFF_FFFF_FFFF_FFFF;
    send_item(it);
    // latest entry, and a limit above the held count
    send_item(dump_item(1));
    send_item(dump_item(64));
    it = note_item(pick_free(1'b1));
    it.time_us = '1;
    send_item(it);
    it = note_item(pick_free(1'b1));
    it.time_us = '0;
    send_item(it);
    send_item(note_item(pick_free(1'b1)));
    send_item(dump_item(0));
    send_item(dump_item(2));
    send_item(dump_item(64));

    // long output hold-off while notes and dumps keep being offered
    hold_req = 1'b1;
    run_random(100);
    end_phase();

    // zero step: any drop below the mark logs
    write_step('0);
    send_item(note_item(sb.lowest));
    send_item(note_item(sb.lowest - 1));
    run_random(80);
    end_phase();

    // largest step: the sum never falls below the mark
    write_step('1);
    run_random(40);
    send_item(dump_item(64));
    end_phase();

    // random step with no idling on either side
    quiet = 1'b1;
    write_step($urandom_range(2, 65535));
    run_random(80);
    end_phase();
    quiet = 1'b0;

    write_step(32'd1);
    run_random(60);
    end_phase();

    // drop to zero free memory
    write_step('0);
    send_item(note_item('0));
    send_item(note_item('0));
    send_item(note_item('1));
    send_item(dump_item(64));
    end_phase();

    if (sb.awaited_q.size() != 0) begin
      sb.errors += sb.awaited_q.size();
      $display("%0t: %0d results never arrived, expected 0 left, actual %0d",
               $time, sb.awaited_q.size(), sb.awaited_q.size());
    end
    $display("run: %0d notes (%0d logged), %0d dumps, %0d results checked",
             sb.notes_seen, sb.logged_seen, sb.dumps_seen, sb.results_seen);
    $display("run: %0d step settings incl. zero and all ones, ring wrap, output hold-off",
             steps_used);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
